// ----- hw/rtl/bfa_pkg.sv -----
// Package for the bitmap first-free allocator.
// Holds sizing constants, command, status and register codes, the FSM type and the word-check struct.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

  // Capacity and word geometry (WORD_BITS must be a power of two)
  localparam int MAX_BITS  = 4096;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = ADDR_W + BIT_W;
  localparam int LIM_W     = $clog2(MAX_BITS + 1);

  // Field widths
  localparam int NUM_W     = 32;
  localparam int TOTAL_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_NUMBER = 1'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
  localparam logic [NUM_W-1:0]   BASE_RESET  = 32'd0;

  // Commands
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RANGE     = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FREE_WR,
    FSM_DONE
  } fsm_t;

  // Outcome of checking one bitmap word during an allocate scan
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
    logic             last;
  } chk_t;

endpackage

// ----- hw/rtl/bfa_if.sv -----
// Valid/ready stream interfaces for the allocator's command and result channels.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

interface bfa_in_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [NUM_W-1:0] number;

  modport source (output valid, output command, output number, input ready);
  modport sink   (input valid, input command, input number, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number_res;
  logic [1:0]       status;

  modport source (output valid, output number_res, output status, input ready);
  modport sink   (input valid, input number_res, input status, output ready);
endinterface

// ----- hw/rtl/bfa_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hw/rtl/bfa_word_chk.sv -----
// Checks one bitmap word for the lowest free entry below the valid count.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_word_chk import bfa_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  logic [ADDR_W-1:0]    word_addr,
  input  logic [LIM_W-1:0]     limit,
  output chk_t                 chk
);

  logic [31:0]          first;
  logic [31:0]          lim32;
  logic [BIT_W:0]       avail;
  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] cand;

  // Number of entries of this word that lie below the count
  always_comb begin
    first = 32'(word_addr) << BIT_W;
    lim32 = 32'(limit);
    if (lim32 <= first) begin
      avail = '0;
    end else if (lim32 - first >= 32'(WORD_BITS)) begin
      avail = (BIT_W + 1)'(WORD_BITS);
    end else begin
      avail = (BIT_W + 1)'(lim32 - first);
    end
  end

  // Free and in-range bits
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      in_range[b] = (avail > (BIT_W + 1)'(b));
    end
    cand = ~word & in_range;
  end

  // Lowest candidate; scan ends at the last word below the count or at the top
  always_comb begin
    chk.found   = |cand;
    chk.bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) chk.bit_idx = BIT_W'(b);
    end
    chk.last = (first + 32'(WORD_BITS) >= lim32) ||
               (word_addr == ADDR_W'(NUM_WORDS - 1));
  end

endmodule

// ----- hw/rtl/bitmap_first_free_allocator_unit.sv -----
// Bitmap first-free allocator: one command at a time, bitmap held in a 1-port RAM.
// Allocate: examines 1..NUM_WORDS words from word zero, one RAM word read per cycle, until a
// free entry or the last valid word is reached. Free: read, write back, result; range error: result only.
// A new command is taken the cycle after the result enters the output register.
// Synchronous active-low reset: FSM idle, count 4096, base 0, per-word valid bits
// cleared so every word reads as all free; no clearing pass is needed.
`timescale 1ns / 1ps

module bitmap_first_free_allocator_unit import bfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  bfa_in_if.sink               in_ch,
  bfa_out_if.source            out_ch
);

  fsm_t state_r, state_nxt;

  logic [TOTAL_W-1:0]   total_r;
  logic [NUM_W-1:0]     base_r;
  logic [LIM_W-1:0]     limit;

  logic [NUM_WORDS-1:0] used_vld_r, used_vld_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]    chk_w_r, chk_w_nxt;
  logic [ADDR_W-1:0]    fr_addr_r, fr_addr_nxt;
  logic [BIT_W-1:0]     fr_bit_r, fr_bit_nxt;
  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic                 res_alloc_r, res_alloc_nxt;
  status_t              res_st_r, res_st_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]     out_num_r, out_num_nxt;
  status_t              out_st_r, out_st_nxt;

  logic                 mem_en, mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata, word_q;

  logic                 in_xfer, out_free;
  logic [NUM_W-1:0]     fr_idx;
  logic                 fr_bad;
  chk_t                 chk;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      base_r  <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOTAL_BITS:  total_r <= cfg_data[TOTAL_W-1:0];
        REG_BASE_NUMBER: base_r  <= cfg_data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid count, capped at capacity
  assign limit = (32'(total_r) > 32'(MAX_BITS)) ? LIM_W'(MAX_BITS) : LIM_W'(total_r);

  // Handshake
  assign in_ch.ready = (state_r == FSM_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.number_res = out_num_r;
  assign out_ch.status     = out_st_r;

  // Free range check on the incoming number
  assign fr_idx = in_ch.number - base_r;
  assign fr_bad = (in_ch.number < base_r) || (fr_idx >= 32'(limit));

  // Words never written read as all free
  assign word_q = rd_vld_r ? mem_rdata : '0;

  bfa_word_chk u_chk (
    .word      (word_q),
    .word_addr (chk_w_r),
    .limit     (limit),
    .chk       (chk)
  );

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_xfer) begin
          if (in_ch.command == CMD_ALLOC) begin
            state_nxt = FSM_SCAN;
          end else if (fr_bad) begin
            state_nxt = FSM_DONE;
          end else begin
            state_nxt = FSM_FREE_WR;
          end
        end
      end
      FSM_SCAN: begin
        if (chk.found || chk.last) state_nxt = FSM_DONE;
      end
      FSM_FREE_WR: state_nxt = FSM_DONE;
      FSM_DONE: begin
        if (out_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, RAM control and output register
  always_comb begin
    used_vld_nxt  = used_vld_r;
    rd_vld_nxt    = rd_vld_r;
    chk_w_nxt     = chk_w_r;
    fr_addr_nxt   = fr_addr_r;
    fr_bit_nxt    = fr_bit_r;
    res_idx_nxt   = res_idx_r;
    res_alloc_nxt = res_alloc_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_num_nxt   = out_num_r;
    out_st_nxt    = out_st_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_xfer) begin
          if (in_ch.command == CMD_ALLOC) begin
            // Start the scan at word zero
            mem_en     = 1'b1;
            mem_addr   = '0;
            rd_vld_nxt = used_vld_r[0];
            chk_w_nxt  = '0;
          end else if (fr_bad) begin
            res_alloc_nxt = 1'b0;
            res_st_nxt    = STAT_RANGE;
          end else begin
            // Fetch the word holding the entry to clear
            mem_en      = 1'b1;
            mem_addr    = fr_idx[BIT_W +: ADDR_W];
            rd_vld_nxt  = used_vld_r[fr_idx[BIT_W +: ADDR_W]];
            fr_addr_nxt = fr_idx[BIT_W +: ADDR_W];
            fr_bit_nxt  = fr_idx[BIT_W-1:0];
          end
        end
      end
      FSM_SCAN: begin
        if (chk.found) begin
          // Claim the bit and write the word back
          mem_en                = 1'b1;
          mem_we                = 1'b1;
          mem_addr              = chk_w_r;
          mem_wdata             = word_q | (WORD_BITS'(1) << chk.bit_idx);
          used_vld_nxt[chk_w_r] = 1'b1;
          res_idx_nxt           = {chk_w_r, chk.bit_idx};
          res_alloc_nxt         = 1'b1;
          res_st_nxt            = STAT_OK;
        end else if (chk.last) begin
          res_alloc_nxt = 1'b0;
          res_st_nxt    = STAT_NONE_FREE;
        end else begin
          // Word full: read the next one while this one is checked
          mem_en     = 1'b1;
          mem_addr   = chk_w_r + ADDR_W'(1);
          rd_vld_nxt = used_vld_r[chk_w_r + ADDR_W'(1)];
          chk_w_nxt  = chk_w_r + ADDR_W'(1);
        end
      end
      FSM_FREE_WR: begin
        mem_en                  = 1'b1;
        mem_we                  = 1'b1;
        mem_addr                = fr_addr_r;
        mem_wdata               = word_q & ~(WORD_BITS'(1) << fr_bit_r);
        used_vld_nxt[fr_addr_r] = 1'b1;
        res_alloc_nxt           = 1'b0;
        res_st_nxt              = STAT_OK;
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = res_alloc_r ? (base_r + NUM_W'(res_idx_r)) : '0;
          out_st_nxt    = res_st_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      used_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_vld_r  <= used_vld_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_w_r     <= chk_w_nxt;
    fr_addr_r   <= fr_addr_nxt;
    fr_bit_r    <= fr_bit_nxt;
    res_idx_r   <= res_idx_nxt;
    res_alloc_r <= res_alloc_nxt;
    res_st_r    <= res_st_nxt;
    out_num_r   <= out_num_nxt;
    out_st_r    <= out_st_nxt;
  end

endmodule

// ----- tb/bitmap_first_free_allocator_unit_test.sv -----
// Self-checking bench for the bitmap first-free allocator: directed table, then random traffic.
// Checks each result against the table's answer or one predicted from a shadow bitmap.
// Depends on bfa_pkg, bfa_if and bitmap_first_free_allocator_unit.
`timescale 1ns / 1ps

module bitmap_first_free_allocator_unit_test;
  import bfa_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES = 150;   // longest allocate scan plus margin

  typedef struct packed {
    logic [NUM_W-1:0] number_res;
    status_t          status;
  } answer_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // arg is the number for a command row, the count data for a config row
  typedef struct packed {
    row_kind_t        kind;
    cmd_t             cmd;
    logic [NUM_W-1:0] arg;
    logic [NUM_W-1:0] base;
    logic             known;
    logic [NUM_W-1:0] exp_num;
    status_t          exp_st;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;

  // Directed table: reset defaults, empty count, wrapping base, count above
  // capacity, lowered count, then back to full size
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd1,          STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'd0,          32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'd4096,       32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CMD, CMD_FREE,  32'd4095,       32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CFG, CMD_ALLOC, 32'd0,          32'd100,        1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_NONE_FREE},
    '{ROW_CMD, CMD_FREE,  32'd100,        32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CFG, CMD_ALLOC, 32'd3,          32'hFFFF_FFFE,  1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_NONE_FREE},
    '{ROW_CMD, CMD_FREE,  32'd5,          32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CMD, CMD_FREE,  32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'hFFFF_FFFF,  STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'd1,          32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CFG, CMD_ALLOC, 32'hFFFF_FFFF,  32'd0,          1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'd4096,       32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CMD, CMD_FREE,  32'd4095,       32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b0, 32'd0,          STAT_OK},
    '{ROW_CFG, CMD_ALLOC, 32'd1,          32'h8000_0000,  1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'd0,          STAT_NONE_FREE},
    '{ROW_CMD, CMD_FREE,  32'h8000_0001,  32'd0,          1'b1, 32'd0,          STAT_RANGE},
    '{ROW_CMD, CMD_FREE,  32'h8000_0000,  32'd0,          1'b1, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b1, 32'h8000_0000,  STAT_OK},
    '{ROW_CFG, CMD_ALLOC, 32'd4096,       32'd0,          1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_FREE,  32'd2,          32'd0,          1'b0, 32'd0,          STAT_OK},
    '{ROW_CMD, CMD_ALLOC, 32'd0,          32'd0,          1'b0, 32'd0,          STAT_OK}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  bitmap_first_free_allocator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow of the allocator state
  logic [WORD_BITS-1:0] shadow_used [NUM_WORDS];
  logic [TOTAL_W-1:0]   cfg_total;
  logic [NUM_W-1:0]     cfg_base;

  answer_t          pending_answers [$];
  logic [NUM_W-1:0] held_numbers [$];   // numbers handed out, candidates for free
  int               mismatches;
  int               gap_pct;
  int               stall_pct;
  int               quiet_cycles;
  bit               offer_up;           // in_ch.valid was last driven high

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int valid_entries();
    return (cfg_total > MAX_BITS) ? MAX_BITS : int'(cfg_total);
  endfunction

  // Expected answer for one command; updates the shadow bitmap
  function automatic answer_t predict_answer(input cmd_t c, input logic [NUM_W-1:0] n);
    answer_t          a;
    int               lim;
    bit               found;
    logic [NUM_W-1:0] idx;
    lim = valid_entries();
    found = 1'b0;
    a.number_res = '0;
    a.status = STAT_OK;
    if (c == CMD_ALLOC) begin
      for (int i = 0; i < lim && !found; i++) begin
        if (!shadow_used[i / WORD_BITS][i % WORD_BITS]) begin
          shadow_used[i / WORD_BITS][i % WORD_BITS] = 1'b1;
          a.number_res = cfg_base + NUM_W'(i);
          found = 1'b1;
        end
      end
      if (!found) a.status = STAT_NONE_FREE;
    end else begin
      idx = n - cfg_base;
      if (n < cfg_base || idx >= NUM_W'(lim)) a.status = STAT_RANGE;
      else shadow_used[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [NUM_W-1:0] got,
                                 input logic [NUM_W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Stop offering and wait until every answer is back
  task automatic drain();
    if (offer_up) begin
      in_ch.valid <= 1'b0;
      offer_up = 1'b0;
    end
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Writes both registers while the block is idle
  task automatic configure(input logic [CFG_W-1:0] total_data, input logic [NUM_W-1:0] base);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TOTAL_BITS;
    cfg_data <= total_data;
    @(posedge clk);
    cfg_total = total_data[TOTAL_W-1:0];
    cfg_idx  <= REG_BASE_NUMBER;
    cfg_data <= base;
    @(posedge clk);
    cfg_base = base;
    cfg_we <= 1'b0;
    held_numbers.delete();
  endtask

  // One command transfer, with a random gap in front
  task automatic issue_cmd(input cmd_t c, input logic [NUM_W-1:0] n, input bit fixed,
                           input answer_t fixed_ans);
    answer_t a;
    if ($urandom_range(99) < gap_pct) begin
      if (offer_up) in_ch.valid <= 1'b0;
      offer_up = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= c;
    in_ch.number  <= n;
    offer_up = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    a = predict_answer(c, n);
    if (c == CMD_ALLOC && a.status == STAT_OK) held_numbers.push_back(a.number_res);
    pending_answers.push_back(fixed ? fixed_ans : a);
  endtask

  // Result side: random stalls, check each transfer against the oldest expected answer
  always @(posedge clk) begin : rx_check
    answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result, number_res", out_ch.number_res, '0);
        end else begin
          want = pending_answers.pop_front();
          if (out_ch.number_res !== want.number_res)
            report_mismatch("number_res", out_ch.number_res, want.number_res);
          if (out_ch.status !== want.status)
            report_mismatch("status", NUM_W'(out_ch.status), NUM_W'(want.status));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               gap_tab   [4] = '{0, 79, 0, 31};
    int               stall_tab [4] = '{0, 0, 79, 31};
    int               n_items;
    int               alloc_pct;
    int               lim;
    int               r;
    int               k;
    logic [CFG_W-1:0] tdata;
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] n;
    answer_t          fixed_ans;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_TOTAL_BITS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ALLOC;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    offer_up = 1'b0;
    foreach (shadow_used[w]) shadow_used[w] = '0;
    cfg_total = TOTAL_RESET;
    cfg_base = BASE_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        configure(plan[i].arg, plan[i].base);
      end else begin
        fixed_ans.number_res = plan[i].exp_num;
        fixed_ans.status = plan[i].exp_st;
        issue_cmd(plan[i].cmd, plan[i].arg, plan[i].known, fixed_ans);
      end
    end

    // Random traffic, three settings per idling phase
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (3) begin
        tdata = $urandom();  // upper bits are don't-care for the count
        case ($urandom_range(9))
          0:       tdata[TOTAL_W-1:0] = '0;
          1:       tdata[TOTAL_W-1:0] = 13'd1;
          2, 3:    tdata[TOTAL_W-1:0] = TOTAL_W'($urandom_range(2, 40));
          4, 5:    tdata[TOTAL_W-1:0] = TOTAL_W'($urandom_range(33, 160));
          6:       tdata[TOTAL_W-1:0] = 13'd4096;
          7:       tdata[TOTAL_W-1:0] = 13'h1FFF;
          8:       tdata[TOTAL_W-1:0] = TOTAL_W'($urandom_range(4097, 8190));
          default: tdata[TOTAL_W-1:0] = TOTAL_W'($urandom());
        endcase
        r = $urandom_range(9);
        if (r < 5) base = $urandom();
        else if (r < 8) base = '0;
        else base = 32'hFFFF_FFFF - $urandom_range(50);
        configure(tdata, base);

        n_items = $urandom_range(30, 50);
        alloc_pct = $urandom_range(40, 85);
        repeat (n_items) begin
          if ($urandom_range(99) < 3) drain();
          lim = valid_entries();
          if ($urandom_range(99) < alloc_pct) begin
            issue_cmd(CMD_ALLOC, $urandom(), 1'b0, fixed_ans);
          end else begin
            r = $urandom_range(99);
            if (r < 50 && held_numbers.size() > 0) begin
              k = $urandom_range(held_numbers.size() - 1);
              n = held_numbers[k];
              held_numbers.delete(k);
            end else if (r < 80) begin
              n = cfg_base + NUM_W'($urandom_range(lim + 2));
            end else if (r < 90) begin
              n = cfg_base - NUM_W'($urandom_range(1, 3));
            end else begin
              n = $urandom();
            end
            issue_cmd(CMD_FREE, n, 1'b0, fixed_ans);
          end
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_word_chk.sv
hw/rtl/bitmap_first_free_allocator_unit.sv
tb/bitmap_first_free_allocator_unit_test.sv
